// ----- design/twlru_pkg.sv -----
`timescale 1ns / 1ps

package twlru_pkg;

  // Address geometry
  localparam int ADDR_W      = 32;
  localparam int OFFSET_BITS = 5;
  localparam int NUM_SETS    = 64;
  localparam int SET_BITS    = $clog2(NUM_SETS);
  localparam int BLOCK_W     = ADDR_W - OFFSET_BITS;
  localparam int TAG_W       = BLOCK_W - SET_BITS;
  localparam int CNT_W       = 32;

  // One set entry as stored in the entry RAM: both way tags and the LRU bit
  typedef struct packed {
    logic             lru;
    logic [TAG_W-1:0] tag1;
    logic [TAG_W-1:0] tag0;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Lookup outcome handed from the decision logic to the control
  typedef struct packed {
    logic             way;
    logic             miss;
    logic             replaced;
    logic [TAG_W-1:0] evicted_tag;
  } decision_t;

endpackage

// ----- design/twlru_ram.sv -----
`timescale 1ns / 1ps

module twlru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/twlru_decide.sv -----
`timescale 1ns / 1ps

module twlru_decide (
  input  logic [twlru_pkg::TAG_W-1:0] tag,
  input  logic [1:0]                  valid,
  input  twlru_pkg::entry_t           entry,
  output twlru_pkg::decision_t        dec,
  output twlru_pkg::entry_t           entry_nxt
);

  // Check both ways, way 0 first; pick a fill or victim way on a miss
  always_comb begin
    dec = '0;
    if (valid[0] && (entry.tag0 == tag)) begin
      dec.way = 1'b0;
    end else if (valid[1] && (entry.tag1 == tag)) begin
      dec.way = 1'b1;
    end else begin
      dec.miss = 1'b1;
      if (!valid[0]) begin
        dec.way = 1'b0;
      end else if (!valid[1]) begin
        dec.way = 1'b1;
      end else begin
        dec.way         = entry.lru;
        dec.replaced    = 1'b1;
        dec.evicted_tag = entry.lru ? entry.tag1 : entry.tag0;
      end
    end
  end

  // Build the write-back entry: install tag on a miss, point LRU at the other way
  always_comb begin
    entry_nxt      = entry;
    entry_nxt.lru  = ~dec.way;
    if (dec.miss && !dec.way) begin
      entry_nxt.tag0 = tag;
    end
    if (dec.miss && dec.way) begin
      entry_nxt.tag1 = tag;
    end
  end

endmodule

// ----- design/two_way_lru_cache_directory.sv -----
`timescale 1ns / 1ps

// Directory of a 2-way set-associative cache (64 sets, 32-byte lines, 32-bit
// byte addresses, LRU replacement). Each request is one address; each result
// gives the address split, the way that hit or was filled, the miss flag, the
// evicted tag (0 when nothing was evicted) and the running hit and miss
// totals, which wrap at 2^32. The set's entry (both tags and the LRU bit) is
// read from the entry RAM when a request is accepted; the lookup state then
// decides and writes the entry back, waiting while a result is not taken. A
// new request is taken only once the lookup is done. Valid bits are flip-flops
// cleared at reset, so the block is ready after reset with no clearing pass.
// The result register lets the next request be taken while a result waits.
module two_way_lru_cache_directory (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [twlru_pkg::ADDR_W-1:0]     in_address,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [twlru_pkg::OFFSET_BITS-1:0] out_byte_offset,
  output logic [twlru_pkg::BLOCK_W-1:0]    out_block_number,
  output logic [twlru_pkg::SET_BITS-1:0]   out_set_index,
  output logic                             out_way_used,
  output logic [twlru_pkg::TAG_W-1:0]      out_tag_value,
  output logic                             out_is_miss,
  output logic                             out_replaced_valid,
  output logic [twlru_pkg::TAG_W-1:0]      out_evicted_tag,
  output logic [twlru_pkg::CNT_W-1:0]      out_hit_total,
  output logic [twlru_pkg::CNT_W-1:0]      out_miss_total
);

  typedef enum logic {
    S_IDLE,
    S_LOOKUP
  } state_t;

  state_t                               state_r;
  logic [twlru_pkg::ADDR_W-1:0]         addr_r;
  logic [twlru_pkg::NUM_SETS-1:0]       valid0_r;
  logic [twlru_pkg::NUM_SETS-1:0]       valid1_r;
  logic [twlru_pkg::CNT_W-1:0]          hit_cnt_r;
  logic [twlru_pkg::CNT_W-1:0]          miss_cnt_r;
  logic [twlru_pkg::CNT_W-1:0]          hit_cnt_nxt;
  logic [twlru_pkg::CNT_W-1:0]          miss_cnt_nxt;

  logic                                 out_valid_r;
  logic [twlru_pkg::OFFSET_BITS-1:0]    offset_r;
  logic [twlru_pkg::BLOCK_W-1:0]        block_r;
  logic [twlru_pkg::SET_BITS-1:0]       set_out_r;
  logic                                 way_r;
  logic [twlru_pkg::TAG_W-1:0]          tag_out_r;
  logic                                 miss_r;
  logic                                 replaced_r;
  logic [twlru_pkg::TAG_W-1:0]          evicted_r;

  logic                                 accept;
  logic                                 fire;
  logic [twlru_pkg::SET_BITS-1:0]       set_idx;
  logic [twlru_pkg::TAG_W-1:0]          tag;
  logic [twlru_pkg::ENTRY_W-1:0]        rd_data;
  twlru_pkg::entry_t                    entry;
  twlru_pkg::entry_t                    entry_nxt;
  twlru_pkg::decision_t                 dec;
  logic [1:0]                           valid_pair;

  // Handshake
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign fire     = (state_r == S_LOOKUP) && (!out_valid_r || out_ready);

  // Split the held address
  assign set_idx = addr_r[twlru_pkg::OFFSET_BITS +: twlru_pkg::SET_BITS];
  assign tag     = addr_r[twlru_pkg::ADDR_W-1 -: twlru_pkg::TAG_W];

  // Entry RAM: read at accept, write back when the request completes
  twlru_ram #(
    .WIDTH (twlru_pkg::ENTRY_W),
    .DEPTH (twlru_pkg::NUM_SETS)
  ) u_entry_ram (
    .clk   (clk),
    .we    (fire),
    .waddr (set_idx),
    .wdata (entry_nxt),
    .re    (accept),
    .raddr (in_address[twlru_pkg::OFFSET_BITS +: twlru_pkg::SET_BITS]),
    .rdata (rd_data)
  );

  assign entry      = twlru_pkg::entry_t'(rd_data);
  assign valid_pair = {valid1_r[set_idx], valid0_r[set_idx]};

  twlru_decide u_decide (
    .tag       (tag),
    .valid     (valid_pair),
    .entry     (entry),
    .dec       (dec),
    .entry_nxt (entry_nxt)
  );

  // Advance the totals, this request included
  assign hit_cnt_nxt  = hit_cnt_r + twlru_pkg::CNT_W'(!dec.miss);
  assign miss_cnt_nxt = miss_cnt_r + twlru_pkg::CNT_W'(dec.miss);

  // Capture the request address
  always_ff @(posedge clk) begin
    if (accept) begin
      addr_r <= in_address;
    end
  end

  // Sequencer, valid bits, totals and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      valid0_r    <= '0;
      valid1_r    <= '0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_LOOKUP;
          end
          if (out_ready) begin
            out_valid_r <= 1'b0;
          end
        end
        S_LOOKUP: begin
          if (fire) begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b1;
            hit_cnt_r   <= hit_cnt_nxt;
            miss_cnt_r  <= miss_cnt_nxt;
            if (dec.miss && !dec.way) begin
              valid0_r[set_idx] <= 1'b1;
            end
            if (dec.miss && dec.way) begin
              valid1_r[set_idx] <= 1'b1;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (fire) begin
      offset_r   <= addr_r[twlru_pkg::OFFSET_BITS-1:0];
      block_r    <= addr_r[twlru_pkg::ADDR_W-1:twlru_pkg::OFFSET_BITS];
      set_out_r  <= set_idx;
      way_r      <= dec.way;
      tag_out_r  <= tag;
      miss_r     <= dec.miss;
      replaced_r <= dec.replaced;
      evicted_r  <= dec.evicted_tag;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_byte_offset    = offset_r;
  assign out_block_number   = block_r;
  assign out_set_index      = set_out_r;
  assign out_way_used       = way_r;
  assign out_tag_value      = tag_out_r;
  assign out_is_miss        = miss_r;
  assign out_replaced_valid = replaced_r;
  assign out_evicted_tag    = evicted_r;
  assign out_hit_total      = hit_cnt_r;
  assign out_miss_total     = miss_cnt_r;

endmodule
